// File: sv/rsk_pkg.sv
// Shared types, codes and sizes for the record stack with key extract.
package rsk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OCC_W     = 5;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP     = 2'd1;
  localparam logic [1:0] CMD_EXTRACT = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [31:0] NONE_WORD = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [30:0]        entry_id;
    logic signed [31:0] entry_serial;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_id;
    logic signed [31:0] out_serial;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic [30:0]        id;
    logic signed [31:0] serial;
  } rec_t;

  // read port address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,   // top of stack, pointer follows
    RD_DOWN,  // pointer minus one, pointer follows
    RD_UP     // pointer plus one
  } rd_op_t;

  typedef struct packed {
    rd_op_t     rd_op;
    logic       cap;        // capture request
    logic       push_wr;    // write request on top, count up
    logic       shift_wr;   // write read data at pointer, pointer up
    logic       dec_fill;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_data;   // result carries read record
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       hit;
    logic       ptr_zero;
    logic       ptr_next_is_fill;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: sv/record_stack_with_key_extract.sv
// Top level: bounded record stack with pop and extract by id.
//
// Input channel (in_valid/in_ready/in_data) carries one request: push a
// record, pop the top record, or extract the topmost record with a given id.
// Result channel (out_valid/out_ready/out_data) returns exactly one result
// per request: status, removed id and serial (-1 when nothing removed),
// and the record count after the operation.
// Steps per request, from acceptance to result in the output register: a push
//   or empty/unknown request is decided in the dispatch state; a pop reads the top;
//   an extract scans down from the top, one record at a time, until a hit or the
//   bottom; a hit below the top then shifts every record above it down one slot.
// The scan walks one memory entry per cycle through the single read port;
// the shift moves each entry with a read state and then a write state on the same port.
// One request at a time; in_ready is high only when idle. A finished result
// waits in the output register while the next request is already accepted;
// a stalled receiver holds back only the next result.
// Reset (rst_n low, synchronous) empties the stack and drops a pending
// result. No memory clearing is needed: only slots below the count are read.
module record_stack_with_key_extract #(
  parameter int DEPTH = rsk_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsk_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsk_pkg::out_item_t out_data
);

  rsk_pkg::ctrl_cmd_t cmd;
  rsk_pkg::dp_stat_t  stat;

  // sequencer
  rsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, pointers and result path
  rsk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/rsk_dp.sv
// Datapath: record memory, fill count, scan pointer and result register.
module rsk_dp #(
  parameter int DEPTH = rsk_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsk_pkg::in_item_t    in_data,
  input  rsk_pkg::ctrl_cmd_t   cmd,
  output rsk_pkg::dp_stat_t    stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsk_pkg::out_item_t   out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsk_pkg::rec_t      mem [DEPTH];
  rsk_pkg::rec_t      rdata_r;
  rsk_pkg::in_item_t  req_r;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      top;
  logic [AW-1:0]      rd_addr;
  logic [1:0]         res_status_r;
  logic signed [31:0] res_id_r, res_serial_r;
  rsk_pkg::out_item_t out_r;
  logic               out_valid_r, out_valid_nxt;

  assign top = AW'(fill_r - CW'(1));

  always_comb begin
    ptr_nxt = ptr_r;
    rd_addr = ptr_r;
    case (cmd.rd_op)
      rsk_pkg::RD_TOP: begin
        rd_addr = top;
        ptr_nxt = top;
      end
      rsk_pkg::RD_DOWN: begin
        rd_addr = ptr_r - AW'(1);
        ptr_nxt = ptr_r - AW'(1);
      end
      rsk_pkg::RD_UP: rd_addr = ptr_r + AW'(1);
      default: rd_addr = ptr_r;
    endcase
    if (cmd.shift_wr) begin
      ptr_nxt = ptr_r + AW'(1);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push_wr) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.dec_fill) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[top + AW'(1)] <= '{id: req_r.entry_id, serial: req_r.entry_serial};
    end else if (cmd.shift_wr) begin
      mem[ptr_r] <= rdata_r;
    end
    if (cmd.rd_op != rsk_pkg::RD_NONE) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // push slot is fill_r; top + 1 wraps correctly also when fill is zero

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_data;
    end
    ptr_r <= ptr_nxt;
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_id_r     <= cmd.res_data ? {1'b0, rdata_r.id} : rsk_pkg::NONE_WORD;
      res_serial_r <= cmd.res_data ? rdata_r.serial : rsk_pkg::NONE_WORD;
    end
    if (cmd.out_load) begin
      out_r.status     <= res_status_r;
      out_r.out_id     <= res_id_r;
      out_r.out_serial <= res_serial_r;
      out_r.occupancy  <= rsk_pkg::OCC_W'(fill_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.cmd              = req_r.cmd;
  assign stat.full             = (fill_r == CW'(DEPTH));
  assign stat.empty            = (fill_r == '0);
  assign stat.hit              = (rdata_r.id == req_r.entry_id);
  assign stat.ptr_zero         = (ptr_r == '0);
  assign stat.ptr_next_is_fill = ((CW'(ptr_r) + CW'(1)) == fill_r);
  assign stat.out_free         = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/rsk_ctrl.sv
// Controller: sequences push, pop, scan and shift over the datapath.
module rsk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsk_pkg::dp_stat_t   stat,
  output rsk_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_WAIT,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_op = rsk_pkg::RD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = rsk_pkg::ST_MISS;
        state_nxt      = S_RESP;
        if (stat.cmd == rsk_pkg::CMD_PUSH) begin
          if (stat.full) begin
            cmd.res_status = rsk_pkg::ST_FULL;
          end else begin
            cmd.res_status = rsk_pkg::ST_OK;
            cmd.push_wr    = 1'b1;
          end
        end else if (stat.cmd == rsk_pkg::CMD_POP ||
                     stat.cmd == rsk_pkg::CMD_EXTRACT) begin
          if (!stat.empty) begin
            cmd.set_res = 1'b0;
            cmd.rd_op   = rsk_pkg::RD_TOP;
            state_nxt   = (stat.cmd == rsk_pkg::CMD_POP) ? S_POP_WAIT : S_SCAN;
          end
        end
      end
      S_POP_WAIT: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = rsk_pkg::ST_OK;
        cmd.res_data   = 1'b1;
        cmd.dec_fill   = 1'b1;
        state_nxt      = S_RESP;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = rsk_pkg::ST_OK;
          cmd.res_data   = 1'b1;
          if (stat.ptr_next_is_fill) begin
            cmd.dec_fill = 1'b1;
            state_nxt    = S_RESP;
          end else begin
            state_nxt    = S_SH_RD;
          end
        end else if (stat.ptr_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = rsk_pkg::ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          cmd.rd_op = rsk_pkg::RD_DOWN;
        end
      end
      S_SH_RD: begin
        // fill still holds the old count: stop once the pointer reaches the old top
        if (stat.ptr_next_is_fill) begin
          cmd.dec_fill = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_op = rsk_pkg::RD_UP;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: test/rsk_checker.sv
// Checker: predicts every stack result and compares it with what the block returns.
module rsk_checker #(
  parameter int DEPTH = rsk_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rsk_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rsk_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the stack, slot 0 at the bottom
  logic [30:0]        shadow_ids [DEPTH];
  logic signed [31:0] shadow_serials [DEPTH];
  int                 shadow_fill;

  rsk_pkg::out_item_t expected_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
    shadow_fill = 0;
  end

  // Applies one request to the shadow stack and returns the result it must give.
  function automatic rsk_pkg::out_item_t stack_apply(input rsk_pkg::in_item_t req);
    rsk_pkg::out_item_t res;
    int                 pos;
    bit                 found;
    res.status     = rsk_pkg::ST_MISS;
    res.out_id     = rsk_pkg::NONE_WORD;
    res.out_serial = rsk_pkg::NONE_WORD;
    found = 1'b0;
    case (req.cmd)
      rsk_pkg::CMD_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = rsk_pkg::ST_FULL;
        end else begin
          shadow_ids[shadow_fill]     = req.entry_id;
          shadow_serials[shadow_fill] = req.entry_serial;
          shadow_fill++;
          res.status = rsk_pkg::ST_OK;
        end
      end
      rsk_pkg::CMD_POP: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          res.status     = rsk_pkg::ST_OK;
          res.out_id     = {1'b0, shadow_ids[shadow_fill]};
          res.out_serial = shadow_serials[shadow_fill];
        end
      end
      rsk_pkg::CMD_EXTRACT: begin
        // topmost match wins; records above it slide down one slot
        for (pos = shadow_fill - 1; pos >= 0 && !found; pos--) begin
          if (shadow_ids[pos] == req.entry_id) begin
            found          = 1'b1;
            res.status     = rsk_pkg::ST_OK;
            res.out_id     = {1'b0, shadow_ids[pos]};
            res.out_serial = shadow_serials[pos];
            for (int j = pos; j + 1 < shadow_fill; j++) begin
              shadow_ids[j]     = shadow_ids[j + 1];
              shadow_serials[j] = shadow_serials[j + 1];
            end
            shadow_fill--;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = shadow_fill[rsk_pkg::OCC_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rsk_pkg::out_item_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(stack_apply(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d id %0d serial %0d",
                 out_data.status, out_data.out_id, out_data.out_serial);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.out_id !== want.out_id) begin
            $error("out_id: expected %0d, got %0d", want.out_id, out_data.out_id);
            fail_count++;
          end
          if (out_data.out_serial !== want.out_serial) begin
            $error("out_serial: expected %0d, got %0d", want.out_serial, out_data.out_serial);
            fail_count++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_data.occupancy);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// File: test/testbench.sv
// Testbench top: drives push, pop and extract requests and reports the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = rsk_pkg::DEPTH_DEF;
  localparam int RANDOM_REQS = 1375;
  localparam int HOLD_CYCLES = 250;      // long receiver stall, fills the block
  localparam int DRAIN       = 120;      // longer than the slowest extract
  localparam int LIMIT       = 400000;   // several times the slowest clean run

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rsk_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rsk_pkg::out_item_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm        = 1'b0;   // no random idling on either side while set

  record_stack_with_key_extract #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rsk_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic rsk_pkg::in_item_t make_req(input logic [1:0] cmd,
                                                 input logic [30:0] id,
                                                 input logic signed [31:0] serial);
    rsk_pkg::in_item_t req;
    req.cmd          = cmd;
    req.entry_id     = id;
    req.entry_serial = serial;
    return req;
  endfunction

  // Ids mostly from a tiny pool so extracts hit and duplicates stack up.
  function automatic logic [30:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 31'($urandom_range(5));
    if (r < 74) return '0;
    if (r < 78) return '1;
    return 31'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_serial();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'sh8000_0000;
    if (r < 8) return 32'sh7FFF_FFFF;
    if (r < 12) return rsk_pkg::NONE_WORD;
    return $signed($urandom);
  endfunction

  // mode 0 leans to filling, 1 to draining, 2 is mixed
  function automatic rsk_pkg::in_item_t pick_req(input int mode);
    int          r;
    int          push_pct;
    logic [1:0]  cmd;
    r = $urandom_range(99);
    push_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 45;
    if (r < push_pct)                            cmd = rsk_pkg::CMD_PUSH;
    else if (r < push_pct + (97 - push_pct) / 2) cmd = rsk_pkg::CMD_POP;
    else if (r < 97)                             cmd = rsk_pkg::CMD_EXTRACT;
    else                                         cmd = rsk_pkg::CMD_UNUSED;
    return make_req(cmd, pick_id(), pick_serial());
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_req(input rsk_pkg::in_item_t req);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 38) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random back-pressure, plus two long hold-offs while requests keep coming.
  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 7000) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(99) < 38) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases first
    send_req(make_req(rsk_pkg::CMD_POP, '0, '0));
    send_req(make_req(rsk_pkg::CMD_EXTRACT, 31'd5, '0));
    send_req(make_req(rsk_pkg::CMD_UNUSED, '1, '1));
    // field extremes, then a duplicate id so extract must take the top one
    send_req(make_req(rsk_pkg::CMD_PUSH, '0, 32'sh8000_0000));
    send_req(make_req(rsk_pkg::CMD_PUSH, '1, 32'sh7FFF_FFFF));
    send_req(make_req(rsk_pkg::CMD_PUSH, 31'd5, 32'sd0));
    send_req(make_req(rsk_pkg::CMD_PUSH, 31'd5, rsk_pkg::NONE_WORD));
    send_req(make_req(rsk_pkg::CMD_EXTRACT, 31'd5, '0));
    send_req(make_req(rsk_pkg::CMD_EXTRACT, 31'd99, '0));   // no match
    send_req(make_req(rsk_pkg::CMD_EXTRACT, '0, '0));       // bottom record, shifts all above
    send_req(make_req(rsk_pkg::CMD_POP, '0, '0));
    // fill to the top (one record is already in), so the last loop push is rejected
    for (int i = 0; i < DEPTH; i++)
      send_req(make_req(rsk_pkg::CMD_PUSH, 31'(1000 + i), $signed($urandom)));
    send_req(make_req(rsk_pkg::CMD_PUSH, 31'd7, 32'sd7));   // full, rejected
    send_req(make_req(rsk_pkg::CMD_EXTRACT, '1, '0));       // bottom of a full stack

    // random: bursts that fill, drain or mix
    mode = 2;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      calm = (n >= 500 && n < 700);
      send_req(pick_req(mode));
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // wait out the last results, then a little more for anything stray
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
